// ----- rtl/ksds_pkg.sv -----
// ----------------------------------------------------------------------------
// ksds_pkg
// Shared widths, register codes and queue entry flags for the K-smallest
// distance selector.
// ----------------------------------------------------------------------------
package ksds_pkg;

	localparam int DIST_W     = 31;
	localparam int RANK_W     = 4;
	localparam int COUNT_W    = 5;
	localparam int SELF_W     = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_COUNT_OF_MINS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELF_INDEX    = 1'd1;

	typedef struct packed {
		logic keep;   // candidate takes part in insertion
		logic last;   // final candidate of the query
	} item_flags_t;

endpackage

// ----- rtl/ksds_front.sv -----
// ----------------------------------------------------------------------------
// ksds_front
// Input stage: registers each candidate and marks whether it is the query
// object itself before it enters the queue.
// ----------------------------------------------------------------------------
module ksds_front #(
	parameter int INDEX_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_valid,
	output logic                         s_ready,
	input  logic [INDEX_BITS-1:0]        s_index,
	input  logic [ksds_pkg::DIST_W-1:0]  s_distance,
	input  logic                         s_last,
	input  logic [INDEX_BITS-1:0]        self_index,
	output logic                         push_valid,
	input  logic                         push_ready,
	output logic [INDEX_BITS-1:0]        push_index,
	output logic [ksds_pkg::DIST_W-1:0]  push_distance,
	output ksds_pkg::item_flags_t        push_flags
);
	import ksds_pkg::*;

	logic                  valid_s1;
	logic [INDEX_BITS-1:0] index_s1;
	logic [DIST_W-1:0]     dist_s1;
	item_flags_t           flags_s1;

	assign s_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) begin
			index_s1      <= s_index;
			dist_s1       <= s_distance;
			flags_s1.keep <= (s_index != self_index);
			flags_s1.last <= s_last;
		end
	end

	assign push_valid    = valid_s1;
	assign push_index    = index_s1;
	assign push_distance = dist_s1;
	assign push_flags    = flags_s1;

endmodule

// ----- rtl/ksds_queue.sv -----
// ----------------------------------------------------------------------------
// ksds_queue
// Small FIFO between the input stage and the sorted list.
// ----------------------------------------------------------------------------
module ksds_queue #(
	parameter int WIDTH = 45,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/ksds_back.sv -----
// ----------------------------------------------------------------------------
// ksds_back
// Sorted list of the K smallest distances with parallel compare and shift
// insert, plus a readout shift register that holds a finished run.
// ----------------------------------------------------------------------------
module ksds_back #(
	parameter int MAX_K      = 16,
	parameter int INDEX_BITS = 12,
	parameter int KW         = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  ksds_pkg::item_flags_t        pop_flags,
	input  logic [INDEX_BITS-1:0]        pop_index,
	input  logic [ksds_pkg::DIST_W-1:0]  pop_distance,
	input  logic [KW-1:0]                k_eff,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ksds_pkg::RANK_W-1:0]  out_rank,
	output logic [INDEX_BITS-1:0]        out_index,
	output logic                         out_found,
	output logic                         out_last
);
	import ksds_pkg::*;

	localparam int RW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

	logic [DIST_W-1:0]     dist_q   [MAX_K];
	logic [INDEX_BITS-1:0] idx_q    [MAX_K];
	logic [MAX_K-1:0]      val_q;

	logic [DIST_W-1:0]     nd       [MAX_K];
	logic [INDEX_BITS-1:0] ni       [MAX_K];
	logic [MAX_K-1:0]      nv;
	logic [MAX_K-1:0]      in_k;
	logic [MAX_K-1:0]      gt;
	logic [MAX_K-1:0]      prior_gt;

	logic [INDEX_BITS-1:0] snap_idx_q   [MAX_K];
	logic [MAX_K-1:0]      snap_found_q;
	logic [RW-1:0]         rank_q;
	logic [KW-1:0]         remain_q;
	logic                  busy_q;

	logic pop_fire;
	logic out_fire;
	logic load;

	// compare against every slot inside K, then find the first larger one
	always_comb begin
		for (int s = 0; s < MAX_K; s++) begin
			in_k[s] = (32'(s) < 32'(k_eff));
			gt[s]   = in_k[s] && (!val_q[s] || (dist_q[s] > pop_distance));
		end
		prior_gt[0] = 1'b0;
		for (int s = 1; s < MAX_K; s++) begin
			prior_gt[s] = prior_gt[s-1] | gt[s-1];
		end
	end

	always_comb begin
		for (int s = 0; s < MAX_K; s++) begin
			nd[s] = dist_q[s];
			ni[s] = idx_q[s];
			nv[s] = val_q[s];
			if (pop_flags.keep && gt[s] && !prior_gt[s]) begin
				nd[s] = pop_distance;
				ni[s] = pop_index;
				nv[s] = 1'b1;
			end
		end
		for (int s = 1; s < MAX_K; s++) begin
			if (pop_flags.keep && in_k[s] && prior_gt[s]) begin
				nd[s] = dist_q[s-1];
				ni[s] = idx_q[s-1];
				nv[s] = val_q[s-1];
			end
		end
	end

	assign out_fire  = busy_q && out_ready;
	assign pop_ready = !pop_flags.last || !busy_q || (out_ready && remain_q == KW'(1));
	assign pop_fire  = pop_valid && pop_ready;
	assign load      = pop_fire && pop_flags.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q    <= '0;
			busy_q   <= 1'b0;
			rank_q   <= '0;
			remain_q <= '0;
		end else begin
			if (pop_fire) begin
				val_q <= pop_flags.last ? '0 : nv;
			end
			if (load) begin
				busy_q   <= 1'b1;
				rank_q   <= '0;
				remain_q <= k_eff;
			end else if (out_fire) begin
				busy_q   <= (remain_q != KW'(1));
				rank_q   <= rank_q + RW'(1);
				remain_q <= remain_q - KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			for (int s = 0; s < MAX_K; s++) begin
				dist_q[s] <= nd[s];
				idx_q[s]  <= ni[s];
			end
		end
		if (load) begin
			for (int s = 0; s < MAX_K; s++) begin
				snap_idx_q[s]   <= nv[s] ? ni[s] : '0;
				snap_found_q[s] <= nv[s];
			end
		end else if (out_fire) begin
			for (int s = 0; s < MAX_K - 1; s++) begin
				snap_idx_q[s]   <= snap_idx_q[s+1];
				snap_found_q[s] <= snap_found_q[s+1];
			end
		end
	end

	assign out_valid = busy_q;
	assign out_rank  = RANK_W'(rank_q);
	assign out_index = snap_idx_q[0];
	assign out_found = snap_found_q[0];
	assign out_last  = (remain_q == KW'(1));

endmodule

// ----- rtl/k_smallest_distance_select.sv -----
// One candidate is taken per cycle unless the queue is full. Each passes
// through an input register, a four-entry queue and the sorted list, where
// MAX_K comparators and a shift insert place it, so a candidate is held in
// the input register and then in the queue before it reaches the list. On a
// candidate with tlast the list is copied into a readout shift register and
// cleared in the same cycle, and the K results of the run leave one per cycle
// while m_axis_tready is high. A tlast candidate waits in the queue only while
// the previous run is still being read out; other candidates keep flowing.
// ----------------------------------------------------------------------------
// k_smallest_distance_select
// Streaming selection of the K smallest distances of a query, with their
// candidate indices, in ascending order.
// ----------------------------------------------------------------------------
module k_smallest_distance_select #(
	parameter int MAX_K      = 16,
	parameter int INDEX_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	// tdata: candidate_index, distance
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((INDEX_BITS+31+7)/8)*8-1:0]     s_axis_tdata,
	input  logic                                   s_axis_tlast,
	// tdata: rank, neighbour_index
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [((INDEX_BITS+4+7)/8)*8-1:0]      m_axis_tdata,
	// tuser: found
	output logic                                   m_axis_tuser,
	output logic                                   m_axis_tlast,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ksds_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ksds_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import ksds_pkg::*;

	localparam int OUT_TW = ((INDEX_BITS + RANK_W + 7) / 8) * 8;
	localparam int KW     = $clog2(MAX_K + 1);
	localparam int FW     = $bits(item_flags_t);
	localparam int QW     = FW + DIST_W + INDEX_BITS;

	logic [COUNT_W-1:0]    count_of_mins_q;
	logic [SELF_W-1:0]     self_index_q;
	logic [KW-1:0]         k_eff;

	logic                  push_valid;
	logic                  push_ready;
	logic [INDEX_BITS-1:0] push_index;
	logic [DIST_W-1:0]     push_distance;
	item_flags_t           push_flags;

	logic                  pop_valid;
	logic                  pop_ready;
	logic [QW-1:0]         pop_data;
	item_flags_t           pop_flags;

	logic [RANK_W-1:0]     out_rank;
	logic [INDEX_BITS-1:0] out_index;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_of_mins_q <= COUNT_W'(4);
			self_index_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COUNT_OF_MINS: count_of_mins_q <= cfg_data[COUNT_W-1:0];
				REG_SELF_INDEX:    self_index_q    <= cfg_data[SELF_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything above MAX_K as MAX_K
	always_comb begin
		if (count_of_mins_q == '0) begin
			k_eff = KW'(1);
		end else if (32'(count_of_mins_q) > MAX_K) begin
			k_eff = KW'(MAX_K);
		end else begin
			k_eff = KW'(count_of_mins_q);
		end
	end

	ksds_front #(
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_valid       (s_axis_tvalid),
		.s_ready       (s_axis_tready),
		.s_index       (s_axis_tdata[INDEX_BITS-1:0]),
		.s_distance    (s_axis_tdata[INDEX_BITS+DIST_W-1:INDEX_BITS]),
		.s_last        (s_axis_tlast),
		.self_index    (INDEX_BITS'(self_index_q)),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_index    (push_index),
		.push_distance (push_distance),
		.push_flags    (push_flags)
	);

	ksds_queue #(
		.WIDTH (QW),
		.DEPTH (4)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_flags, push_distance, push_index}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_flags = item_flags_t'(pop_data[QW-1:INDEX_BITS+DIST_W]);

	ksds_back #(
		.MAX_K      (MAX_K),
		.INDEX_BITS (INDEX_BITS),
		.KW         (KW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_flags    (pop_flags),
		.pop_index    (pop_data[INDEX_BITS-1:0]),
		.pop_distance (pop_data[INDEX_BITS+DIST_W-1:INDEX_BITS]),
		.k_eff        (k_eff),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_rank     (out_rank),
		.out_index    (out_index),
		.out_found    (m_axis_tuser),
		.out_last     (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_TW'({out_index, out_rank});

	// a new run always starts at rank zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast)
		|=> (!m_axis_tvalid || out_rank == '0))
	else $error("run readout did not restart at rank zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		(k_eff != '0) && (32'(k_eff) <= MAX_K))
	else $error("effective K out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (out_index == '0))
	else $error("empty slot reported a nonzero index");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast)
		|=> (m_axis_tvalid && out_rank == $past(out_rank) + RANK_W'(1)))
	else $error("readout skipped or repeated a rank");

endmodule
